>>> hw/rtl/bmm_pkg.sv
// ----------------------------------------------------------------------------
// bmm_pkg: shared types and constants for the bounded multimap table
// Operation and status codes, controller states and the control part of the
// search token that travels down the row of entry cells.
// ----------------------------------------------------------------------------
package bmm_pkg;

	// fixed widths of the channel fields
	localparam int FIELD_W  = 32;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// per-key value limit and capacity register reset
	localparam logic [1:0]         MAX_PER_KEY = 2'd2;
	localparam logic [COUNT_W-1:0] CAP_RESET   = 5'd16;

	typedef enum logic [KIND_W-1:0] {
		OP_ADD    = 2'd0,
		OP_SEARCH = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NONE   = 2'd3
	} op_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} ctrl_state_t;

	// control part of the token handed from cell to cell
	typedef struct packed {
		logic       vld;
		op_kind_t   kind;
		logic [1:0] found;
		logic       hit;
	} tok_ctl_t;

endpackage

>>> hw/rtl/bmm_if.sv
// ----------------------------------------------------------------------------
// bmm_if: request and response channels of the bounded multimap table
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface bmm_req_if;
	import bmm_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [KIND_W-1:0]          kind;
	logic signed [FIELD_W-1:0]  key;
	logic signed [FIELD_W-1:0]  value;

	modport source (output valid, output kind, output key, output value, input ready);
	modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

interface bmm_rsp_if;
	import bmm_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [STATUS_W-1:0]        status;
	logic                       first_valid;
	logic signed [FIELD_W-1:0]  first_value;
	logic                       second_valid;
	logic signed [FIELD_W-1:0]  second_value;
	logic [COUNT_W-1:0]         entry_count;
	logic                       is_empty;
	logic                       is_full;

	modport source (output valid, output status, output first_valid, output first_value,
		output second_valid, output second_value, output entry_count, output is_empty,
		output is_full, input ready);
	modport sink   (input valid, input status, input first_valid, input first_value,
		input second_valid, input second_value, input entry_count, input is_empty,
		input is_full, output ready);
endinterface

>>> hw/rtl/bmm_cell.sv
// ----------------------------------------------------------------------------
// bmm_cell: one entry of the table
// Holds one key/value pair, updates the passing search token against it and
// hands the token to the next cell through its token stage register.
// ----------------------------------------------------------------------------
module bmm_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int IDX_W      = 4,
	parameter int CNT_W      = 5,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// token from the previous cell
	input  bmm_pkg::tok_ctl_t     ctl_i,
	input  logic [DATA_WIDTH-1:0] key_i,
	input  logic [DATA_WIDTH-1:0] val_i,
	input  logic [DATA_WIDTH-1:0] v1_i,
	input  logic [DATA_WIDTH-1:0] v2_i,
	input  logic [IDX_W-1:0]      hit_idx_i,
	// token to the next cell
	output bmm_pkg::tok_ctl_t     ctl_o,
	output logic [DATA_WIDTH-1:0] key_o,
	output logic [DATA_WIDTH-1:0] val_o,
	output logic [DATA_WIDTH-1:0] v1_o,
	output logic [DATA_WIDTH-1:0] v2_o,
	output logic [IDX_W-1:0]      hit_idx_o,
	// pair count and write-back port
	input  logic [CNT_W-1:0]      cnt,
	input  logic                  wr_en,
	input  logic [IDX_W-1:0]      wr_idx,
	input  logic [DATA_WIDTH-1:0] wr_key,
	input  logic [DATA_WIDTH-1:0] wr_val
);
	import bmm_pkg::*;

	logic [DATA_WIDTH-1:0] ent_key_q;
	logic [DATA_WIDTH-1:0] ent_val_q;

	tok_ctl_t              ctl_d,   ctl_q;
	logic [DATA_WIDTH-1:0] v1_d,    v1_q;
	logic [DATA_WIDTH-1:0] v2_d,    v2_q;
	logic [IDX_W-1:0]      hit_d,   hit_q;
	logic [DATA_WIDTH-1:0] key_q,   val_q;

	logic active;
	logic is_last;
	logic key_hit;

	// entry is live when below the pair count
	assign active  = CNT_W'(INDEX) < cnt;
	assign is_last = CNT_W'(INDEX + 1) == cnt;
	assign key_hit = active && (ent_key_q == key_i);

	// token update against this entry
	always_comb begin
		ctl_d = ctl_i;
		v1_d  = v1_i;
		v2_d  = v2_i;
		hit_d = hit_idx_i;
		unique case (ctl_i.kind)
			OP_ADD: begin
				if (key_hit && ctl_i.found < MAX_PER_KEY) begin
					ctl_d.found = ctl_i.found + 2'd1;
				end
			end
			OP_SEARCH: begin
				if (key_hit && ctl_i.found < MAX_PER_KEY) begin
					if (ctl_i.found == 2'd0) begin
						v1_d = ent_val_q;
					end else begin
						v2_d = ent_val_q;
					end
					ctl_d.found = ctl_i.found + 2'd1;
				end
			end
			OP_REMOVE: begin
				if (key_hit && !ctl_i.hit && ent_val_q == val_i) begin
					ctl_d.hit = 1'b1;
					hit_d     = IDX_W'(INDEX);
				end
				// last live entry rides along to fill the hole
				if (is_last) begin
					v1_d = ent_key_q;
					v2_d = ent_val_q;
				end
			end
			OP_NONE: begin
			end
		endcase
	end

	// token stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_i;
		val_q <= val_i;
		v1_q  <= v1_d;
		v2_q  <= v2_d;
		hit_q <= hit_d;
	end

	// entry storage, written by the controller after a scan
	always_ff @(posedge clk) begin
		if (wr_en && wr_idx == IDX_W'(INDEX)) begin
			ent_key_q <= wr_key;
			ent_val_q <= wr_val;
		end
	end

	assign ctl_o     = ctl_q;
	assign key_o     = key_q;
	assign val_o     = val_q;
	assign v1_o      = v1_q;
	assign v2_o      = v2_q;
	assign hit_idx_o = hit_q;

endmodule

>>> hw/rtl/bmm_ctrl.sv
// ----------------------------------------------------------------------------
// bmm_ctrl: sequencer of the bounded multimap table
// Launches one token per request into the cell row, collects it at the end,
// writes back adds and removes, and holds the response register.
// ----------------------------------------------------------------------------
module bmm_ctrl #(
	parameter int TABLE_DEPTH = 16,
	parameter int DATA_WIDTH  = 32,
	parameter int IDX_W       = 4,
	parameter int CNT_W       = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	bmm_req_if.sink                     request,
	bmm_rsp_if.source                   response,
	input  logic                        cfg_we,
	input  logic [bmm_pkg::COUNT_W-1:0] cfg_wdata,
	// head of the cell row
	output bmm_pkg::tok_ctl_t           head_ctl,
	output logic [DATA_WIDTH-1:0]       head_key,
	output logic [DATA_WIDTH-1:0]       head_val,
	output logic [DATA_WIDTH-1:0]       head_v1,
	output logic [DATA_WIDTH-1:0]       head_v2,
	output logic [IDX_W-1:0]            head_hit_idx,
	// tail of the cell row
	input  bmm_pkg::tok_ctl_t           tail_ctl,
	input  logic [DATA_WIDTH-1:0]       tail_v1,
	input  logic [DATA_WIDTH-1:0]       tail_v2,
	input  logic [IDX_W-1:0]            tail_hit_idx,
	// count and write-back port to the cells
	output logic [CNT_W-1:0]            cnt,
	output logic                        wr_en,
	output logic [IDX_W-1:0]            wr_idx,
	output logic [DATA_WIDTH-1:0]       wr_key,
	output logic [DATA_WIDTH-1:0]       wr_val
);
	import bmm_pkg::*;

	localparam int CW = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	ctrl_state_t state_q, state_d;

	logic [COUNT_W-1:0]    cap_q;
	logic [CNT_W-1:0]      cnt_q, cnt_nx;
	logic [CW-1:0]         eff_cap;
	logic [CW-1:0]         cap_ext;

	// token as it left the row, with the request key and value from launch
	tok_ctl_t              fin_ctl_q;
	logic [DATA_WIDTH-1:0] fin_key_q, fin_val_q;
	logic [DATA_WIDTH-1:0] fin_v1_q, fin_v2_q;
	logic [IDX_W-1:0]      fin_hit_q;

	logic                  req_fire;
	logic                  out_free;
	logic                  do_finish;

	status_t               res_status;
	logic                  res_fv, res_sv;
	logic                  wr_req;

	logic                  out_vld_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic                  out_fv_q, out_sv_q;
	logic [FIELD_W-1:0]    out_v1_q, out_v2_q;
	logic [COUNT_W-1:0]    out_cnt_q;
	logic                  out_empty_q, out_full_q;

	// effective capacity: register clamped to 1..depth
	assign cap_ext = CW'(cap_q);
	always_comb begin
		priority if (cap_ext == '0) begin
			eff_cap = CW'(1);
		end else if (cap_ext > CW'(TABLE_DEPTH)) begin
			eff_cap = CW'(TABLE_DEPTH);
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign req_fire  = request.valid && request.ready;
	assign out_free  = !out_vld_q || response.ready;
	assign do_finish = (state_q == S_FINISH) && out_free;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (req_fire) state_d = S_SCAN;
			S_SCAN:   if (tail_ctl.vld) state_d = S_FINISH;
			S_FINISH: if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		request.ready = (state_q == S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// token launch
	always_comb begin
		head_ctl.vld   = req_fire;
		head_ctl.kind  = op_kind_t'(request.kind);
		head_ctl.found = 2'd0;
		head_ctl.hit   = 1'b0;
		head_key       = DATA_WIDTH'($unsigned(request.key));
		head_val       = DATA_WIDTH'($unsigned(request.value));
		head_v1        = '0;
		head_v2        = '0;
		head_hit_idx   = '0;
	end

	// capture the token control at the end of the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_ctl_q <= '0;
		end else if (state_q == S_SCAN && tail_ctl.vld) begin
			fin_ctl_q <= tail_ctl;
		end
	end

	// capture the token data at the end of the row, and the request key and value at launch
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && tail_ctl.vld) begin
			fin_v1_q  <= tail_v1;
			fin_v2_q  <= tail_v2;
			fin_hit_q <= tail_hit_idx;
		end
		if (req_fire) begin
			fin_key_q <= head_key;
			fin_val_q <= head_val;
		end
	end

	// result and write-back decision
	always_comb begin
		res_status = ST_MISS;
		res_fv     = 1'b0;
		res_sv     = 1'b0;
		wr_req     = 1'b0;
		wr_idx     = '0;
		wr_key     = fin_key_q;
		wr_val     = fin_val_q;
		cnt_nx     = cnt_q;
		unique case (fin_ctl_q.kind)
			OP_ADD: begin
				priority if (CW'(cnt_q) >= eff_cap) begin
					res_status = ST_FULL;
				end else if (fin_ctl_q.found >= MAX_PER_KEY) begin
					res_status = ST_MISS;
				end else begin
					res_status = ST_DONE;
					wr_req     = 1'b1;
					wr_idx     = IDX_W'(cnt_q);
					cnt_nx     = CNT_W'(cnt_q + 1'b1);
				end
			end
			OP_SEARCH: begin
				res_fv     = fin_ctl_q.found != 2'd0;
				res_sv     = fin_ctl_q.found >= MAX_PER_KEY;
				res_status = res_fv ? ST_DONE : ST_MISS;
			end
			OP_REMOVE: begin
				if (fin_ctl_q.hit) begin
					res_status = ST_DONE;
					wr_req     = 1'b1;
					wr_idx     = fin_hit_q;
					wr_key     = fin_v1_q;
					wr_val     = fin_v2_q;
					cnt_nx     = CNT_W'(cnt_q - 1'b1);
				end
			end
			OP_NONE: begin
			end
		endcase
	end

	assign wr_en = do_finish && wr_req;

	// pair count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (do_finish) begin
			cnt_q <= cnt_nx;
		end
	end

	assign cnt = cnt_q;

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (do_finish) begin
			out_vld_q <= 1'b1;
		end else if (response.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_finish) begin
			out_status_q <= res_status;
			out_fv_q     <= res_fv;
			out_sv_q     <= res_sv;
			out_v1_q     <= res_fv ? FIELD_W'(fin_v1_q) : '0;
			out_v2_q     <= res_sv ? FIELD_W'(fin_v2_q) : '0;
			out_cnt_q    <= COUNT_W'(cnt_nx);
			out_empty_q  <= cnt_nx == '0;
			out_full_q   <= CW'(cnt_nx) >= eff_cap;
		end
	end

	assign response.valid        = out_vld_q;
	assign response.status       = out_status_q;
	assign response.first_valid  = out_fv_q;
	assign response.first_value  = out_v1_q;
	assign response.second_valid = out_sv_q;
	assign response.second_value = out_v2_q;
	assign response.entry_count  = out_cnt_q;
	assign response.is_empty     = out_empty_q;
	assign response.is_full      = out_full_q;

	// count never exceeds the built depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("pair count above table depth");

	// a token only leaves the row while a scan is pending
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail_ctl.vld |-> state_q == S_SCAN)
		else $error("token left the row outside a scan");

	// every write-back changes the pair count
	a_wr_moves_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> cnt_q != $past(cnt_q))
		else $error("write-back without count change");

	// a finished scan is not lost while the response register is busy
	a_finish_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && !out_free) |=> state_q == S_FINISH)
		else $error("finished scan dropped");

endmodule

>>> hw/rtl/bounded_multimap_table.sv
// A request is answered once its token has walked the cell row, through one register per
// cell, and the controller has captured it at the tail and written back adds and removes;
// the answer waits while the response register is still held. One request is in flight
// at a time: a new request is accepted only when the controller is idle again.
// Reset: arst_n clears the pair count, the controller and the response valid, and
// sets the capacity register to 16; entry contents are undefined until written.
// ----------------------------------------------------------------------------
// bounded_multimap_table: key/value table with at most two values per key
// Add, search and remove requests scan a row of entry cells, one cell a cycle.
// ----------------------------------------------------------------------------
module bounded_multimap_table #(
	parameter int TABLE_DEPTH = 16,
	parameter int DATA_WIDTH  = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	bmm_req_if.sink                     request,
	bmm_rsp_if.source                   response,
	input  logic                        cfg_we,
	input  logic [bmm_pkg::COUNT_W-1:0] cfg_wdata
);
	import bmm_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// token taps between cells
	tok_ctl_t              ctl_c [TABLE_DEPTH+1];
	logic [DATA_WIDTH-1:0] key_c [TABLE_DEPTH+1];
	logic [DATA_WIDTH-1:0] val_c [TABLE_DEPTH+1];
	logic [DATA_WIDTH-1:0] v1_c  [TABLE_DEPTH+1];
	logic [DATA_WIDTH-1:0] v2_c  [TABLE_DEPTH+1];
	logic [IDX_W-1:0]      hit_c [TABLE_DEPTH+1];

	logic [CNT_W-1:0]      cnt;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_idx;
	logic [DATA_WIDTH-1:0] wr_key;
	logic [DATA_WIDTH-1:0] wr_val;

	// sequencer
	bmm_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.DATA_WIDTH  (DATA_WIDTH),
		.IDX_W       (IDX_W),
		.CNT_W       (CNT_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.request      (request),
		.response     (response),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.head_ctl     (ctl_c[0]),
		.head_key     (key_c[0]),
		.head_val     (val_c[0]),
		.head_v1      (v1_c[0]),
		.head_v2      (v2_c[0]),
		.head_hit_idx (hit_c[0]),
		.tail_ctl     (ctl_c[TABLE_DEPTH]),
		.tail_v1      (v1_c[TABLE_DEPTH]),
		.tail_v2      (v2_c[TABLE_DEPTH]),
		.tail_hit_idx (hit_c[TABLE_DEPTH]),
		.cnt          (cnt),
		.wr_en        (wr_en),
		.wr_idx       (wr_idx),
		.wr_key       (wr_key),
		.wr_val       (wr_val)
	);

	// row of entry cells
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		bmm_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.IDX_W      (IDX_W),
			.CNT_W      (CNT_W),
			.INDEX      (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl_i     (ctl_c[i]),
			.key_i     (key_c[i]),
			.val_i     (val_c[i]),
			.v1_i      (v1_c[i]),
			.v2_i      (v2_c[i]),
			.hit_idx_i (hit_c[i]),
			.ctl_o     (ctl_c[i+1]),
			.key_o     (key_c[i+1]),
			.val_o     (val_c[i+1]),
			.v1_o      (v1_c[i+1]),
			.v2_o      (v2_c[i+1]),
			.hit_idx_o (hit_c[i+1]),
			.cnt       (cnt),
			.wr_en     (wr_en),
			.wr_idx    (wr_idx),
			.wr_key    (wr_key),
			.wr_val    (wr_val)
		);
	end

endmodule
